@@ hw/rtl/rgb_to_hsi_pixel_top_macros.svh @@
// assertion macros for the rgb to hsi pixel converter
`ifndef RGB_TO_HSI_PIXEL_TOP_MACROS_SVH
`define RGB_TO_HSI_PIXEL_TOP_MACROS_SVH

// implication checked on every rising edge outside reset
`define RHSI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rhsi assertion failed");

// consequence checked in the cycle after the antecedent
`define RHSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rhsi assertion failed");

`endif

@@ hw/rtl/rhsi_pkg.sv @@
// package with types, constants and helpers of the rgb to hsi converter
package rhsi_pkg;

  localparam int unsigned CordicSteps = 20;
  localparam int unsigned DivSteps    = 8;
  localparam int unsigned StepW       = 5;
  localparam int unsigned XyW         = 33;
  localparam int unsigned ZW          = 25;
  localparam int unsigned RemW        = 19;
  localparam int unsigned DenW        = 11;
  localparam int unsigned FracIn      = 20;
  localparam logic [20:0] Sqrt3Q20    = 21'd1816187;
  localparam logic [16:0] Recip3      = 17'd43691;
  localparam logic signed [ZW-1:0] QuarterZ  = ZW'(45 <<< 16);
  localparam logic signed [ZW-1:0] HalfTurnZ = ZW'(90 <<< 16);
  localparam logic signed [ZW-1:0] FullTurnZ = ZW'(180 <<< 16);
  localparam logic signed [ZW-1:0] RoundHalf = ZW'(32768);

  typedef struct packed {
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [ZW-1:0]  z;
    logic [RemW-1:0]       rem;
    logic [DenW-1:0]       den;
    logic [7:0]            quo;
    logic [7:0]            inten;
    logic                  flat;
    logic                  flip;
  } stage_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [StepW-1:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = ZW'(1474560);
      5'd1:    v = ZW'(870484);
      5'd2:    v = ZW'(459940);
      5'd3:    v = ZW'(233473);
      5'd4:    v = ZW'(117189);
      5'd5:    v = ZW'(58652);
      5'd6:    v = ZW'(29333);
      5'd7:    v = ZW'(14667);
      5'd8:    v = ZW'(7334);
      5'd9:    v = ZW'(3667);
      5'd10:   v = ZW'(1833);
      5'd11:   v = ZW'(917);
      5'd12:   v = ZW'(458);
      5'd13:   v = ZW'(229);
      5'd14:   v = ZW'(115);
      5'd15:   v = ZW'(57);
      5'd16:   v = ZW'(29);
      5'd17:   v = ZW'(14);
      5'd18:   v = ZW'(7);
      5'd19:   v = ZW'(4);
      default: v = '0;
    endcase
    return v;
  endfunction

  // arithmetic right shift rounding toward zero
  function automatic logic signed [XyW-1:0] shift_tz(input logic signed [XyW-1:0] v,
                                                     input logic [StepW-1:0] s);
    logic signed [XyW-1:0] r;
    if (v[XyW-1]) begin
      r = -((-v) >>> s);
    end else begin
      r = v >>> s;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/rhsi_front.sv @@
// input stage: channel differences, cordic start vector, divider operands, intensity
module rhsi_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output rhsi_pkg::stage_t      data_o
);
  import rhsi_pkg::*;

  logic                  valid_q;
  stage_t                data_q, data_d;
  logic signed [10:0]    c, d, v;
  logic [7:0]            ad;
  logic [28:0]           py_mag;
  logic signed [XyW-1:0] px, py;
  logic [9:0]            sum, mn3;
  logic [7:0]            mn;
  logic [26:0]           inten_prod;

  always_comb begin
    c  = 11'($signed({1'b0, red_i}))   - 11'($signed({1'b0, blue_i}));
    d  = 11'($signed({1'b0, green_i})) - 11'($signed({1'b0, blue_i}));
    ad = d[10] ? 8'(-d) : d[7:0];
    v  = (c <<< 1) - d;
    px = XyW'(v) <<< FracIn;
    py_mag = 29'(ad) * 29'(Sqrt3Q20);
    py = XyW'($signed({1'b0, py_mag}));

    sum = 10'(red_i) + 10'(green_i) + 10'(blue_i);
    mn  = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    mn3 = 10'(mn) + 10'({mn, 1'b0});
    inten_prod = 27'(sum + 10'd1) * 27'(Recip3);

    data_d = '0;
    if (px[XyW-1]) begin
      data_d.x = py;
      data_d.y = -px;
      data_d.z = QuarterZ;
    end else begin
      data_d.x = px;
      data_d.y = py;
      data_d.z = '0;
    end
    if (sum == '0) begin
      data_d.rem = '0;
      data_d.den = DenW'(1);
    end else begin
      data_d.rem = RemW'(sum - mn3) * RemW'(510) + RemW'(sum);
      data_d.den = {sum, 1'b0};
    end
    data_d.quo   = '0;
    data_d.inten = inten_prod[24:17];
    data_d.flat  = (red_i == green_i) && (green_i == blue_i);
    data_d.flip  = blue_i > green_i;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

@@ hw/rtl/rhsi_cell.sv @@
// one chain cell: a vectoring cordic step and, in the first cells, one quotient bit
module rhsi_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [rhsi_pkg::StepW-1:0]   step_i,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  rhsi_pkg::stage_t             data_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output rhsi_pkg::stage_t             data_o
);
  import rhsi_pkg::*;

  logic                  valid_q;
  stage_t                data_q, data_d;
  logic signed [XyW-1:0] xs, ys;
  logic signed [ZW-1:0]  ang;
  logic [2:0]            bit_sel;
  logic [RemW-1:0]       trial;

  always_comb begin
    data_d = data_i;
    xs  = shift_tz(data_i.x, step_i);
    ys  = shift_tz(data_i.y, step_i);
    ang = atan_lut(step_i);
    if (!data_i.y[XyW-1]) begin
      data_d.x = data_i.x + ys;
      data_d.y = data_i.y - xs;
      data_d.z = data_i.z + ang;
    end else begin
      data_d.x = data_i.x - ys;
      data_d.y = data_i.y + xs;
      data_d.z = data_i.z - ang;
    end
    bit_sel = 3'(DivSteps - 1) - step_i[2:0];
    trial   = RemW'(data_i.den) << bit_sel;
    if ((step_i < StepW'(DivSteps)) && (data_i.rem >= trial)) begin
      data_d.rem = data_i.rem - trial;
      data_d.quo = data_i.quo | (8'd1 << bit_sel);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

@@ hw/rtl/rhsi_back.sv @@
// output stage: angle clamp, half turn fold, hue rounding, output register
module rhsi_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  rhsi_pkg::stage_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [7:0]       hue_o,
  output logic [7:0]       saturation_o,
  output logic [7:0]       intensity_o
);
  import rhsi_pkg::*;

  logic                 valid_q;
  logic [7:0]           hue_q, hue_d, sat_q, int_q;
  logic signed [ZW-1:0] theta, h, hr;

  always_comb begin
    theta = data_i.z;
    if (theta[ZW-1]) theta = '0;
    if (theta > HalfTurnZ) theta = HalfTurnZ;
    h  = data_i.flip ? (FullTurnZ - theta) : theta;
    hr = h + RoundHalf;
    hue_d = data_i.flat ? 8'd0 : hr[23:16];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      hue_q <= hue_d;
      sat_q <= data_i.quo;
      int_q <= data_i.inten;
    end
  end

  assign valid_o      = valid_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign intensity_o  = int_q;
endmodule

@@ hw/rtl/rgb_to_hsi_pixel_top.sv @@
// top level of the rgb to hsi pixel converter
// Converts one 8-bit RGB pixel per clock, unless the output stalls, into 8-bit hue
// (0..180), saturation and intensity. The path is one input stage, a chain of 20
// cordic cells that also carry an 8-step restoring divider for saturation, and one
// output stage. Every stage holds its own transaction and moves on when the next
// one frees, so bubbles close up under backpressure; otherwise a pixel enters each cycle.
module rgb_to_hsi_pixel_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // red, green, blue
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // hue, saturation, intensity
);
  import rhsi_pkg::*;

  logic   valid_s [CordicSteps+1];
  logic   ready_s [CordicSteps+1];
  stage_t data_s  [CordicSteps+1];

  rhsi_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .red_i   (s_axis_tdata[7:0]),
    .green_i (s_axis_tdata[15:8]),
    .blue_i  (s_axis_tdata[23:16]),
    .valid_o (valid_s[0]),
    .ready_i (ready_s[0]),
    .data_o  (data_s[0])
  );

  for (genvar k = 0; k < CordicSteps; k++) begin : g_cell
    rhsi_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (StepW'(k)),
      .valid_i (valid_s[k]),
      .ready_o (ready_s[k]),
      .data_i  (data_s[k]),
      .valid_o (valid_s[k+1]),
      .ready_i (ready_s[k+1]),
      .data_o  (data_s[k+1])
    );
  end

  rhsi_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_s[CordicSteps]),
    .ready_o      (ready_s[CordicSteps]),
    .data_i       (data_s[CordicSteps]),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .hue_o        (m_axis_tdata[7:0]),
    .saturation_o (m_axis_tdata[15:8]),
    .intensity_o  (m_axis_tdata[23:16])
  );
endmodule

@@ hw/rtl/rhsi_checker.sv @@
// port checker for the rgb to hsi pixel converter and its bind
`include "rgb_to_hsi_pixel_top_macros.svh"

module rhsi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  `RHSI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `RHSI_ASSERT_IMP(a_hue_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[7:0] <= 8'd180)
  `RHSI_ASSERT_IMP(a_stall_only_full, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
endmodule

bind rgb_to_hsi_pixel_top rhsi_checker u_rhsi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
